### hw/rtl/tlcc_pkg.sv
// tlcc_pkg: shared types, codes and helpers of the telephone line call control
// used by every module of the block; depends on nothing
`default_nettype none

package tlcc_pkg;

  // number of lines by default
  localparam int LINES_DEFAULT = 16;
  // lines addressable by the 4-bit line fields
  localparam int LINE_FIELD_MAX = 16;
  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_PICKUP = 2'd0,
    CMD_HANGUP = 2'd1,
    CMD_DIAL   = 2'd2,
    CMD_CHAT   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ON_HOOK   = 3'd0,
    ST_RINGING   = 3'd1,
    ST_DIAL_TONE = 3'd2,
    ST_RING_BACK = 3'd3,
    ST_BUSY      = 3'd4,
    ST_CONNECTED = 3'd5,
    ST_ERROR     = 3'd6
  } line_state_e;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_CHAT   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ERR  = 1'b1;

  // classified event as it travels from front to back
  typedef struct packed {
    cmd_e       cmd;
    logic       line_ok;
    logic [3:0] line;
    logic [3:0] target_line;
    logic       target_ok;
  } item_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [3:0]  dest_line;
    line_state_e line_state;
    logic [3:0]  peer_ext;
    logic        status;
    logic        last;
  } res_t;

  // state notice: the peer is only shown while connected
  function automatic res_t make_notice(input logic [3:0] dest, input line_state_e st,
                                       input logic [3:0] peer, input logic status,
                                       input logic last);
    res_t r;
    r.kind       = KIND_NOTICE;
    r.dest_line  = dest;
    r.line_state = st;
    r.peer_ext   = (st == ST_CONNECTED) ? peer : 4'd0;
    r.status     = status;
    r.last       = last;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tlcc_front.sv
// tlcc_front: takes input items, checks line and target against the line count
// and holds one classified item for the queue; uses tlcc_pkg
`default_nettype none

module tlcc_front #(
  parameter int LINES = tlcc_pkg::LINES_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    cmd_i,
  input  wire logic [3:0]    line_i,
  input  wire logic [3:0]    target_line_i,
  input  wire logic          target_valid_i,
  output logic               push_o,
  input  wire logic          full_i,
  output tlcc_pkg::item_t    item_o
);

  logic            front_valid_q, front_valid_d;
  tlcc_pkg::item_t front_q, front_d;
  logic            accept;

  assign in_stall_o = front_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = front_valid_q && !full_i;
  assign item_o     = front_q;

  always_comb begin
    front_d.cmd         = tlcc_pkg::cmd_e'(cmd_i);
    front_d.line        = line_i;
    front_d.line_ok     = 32'(line_i) < 32'(LINES);
    front_d.target_line = target_line_i;
    front_d.target_ok   = target_valid_i && (32'(target_line_i) < 32'(LINES));
    front_valid_d       = accept ? 1'b1 : (front_valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else begin
      front_valid_q <= front_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q <= front_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tlcc_queue.sv
// tlcc_queue: short fifo of classified items between front and back
// uses tlcc_pkg for the item type and depth
`default_nettype none

module tlcc_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tlcc_pkg::item_t  item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output tlcc_pkg::item_t       item_o
);

  localparam int PTRW = (tlcc_pkg::QUEUE_DEPTH > 1) ? $clog2(tlcc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(tlcc_pkg::QUEUE_DEPTH + 1);

  tlcc_pkg::item_t slots_q [tlcc_pkg::QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = count_q == CNTW'(tlcc_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTRW-1:0] next_ptr(input logic [PTRW-1:0] p);
    logic [PTRW-1:0] n;
    n = (32'(p) == tlcc_pkg::QUEUE_DEPTH - 1) ? '0 : p + PTRW'(1);
    return n;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNTW'(do_push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tlcc_back.sv
// tlcc_back: line table memory, event sequencer and result register
// uses tlcc_pkg; fed by tlcc_queue
`default_nettype none

module tlcc_back #(
  parameter int LINES = tlcc_pkg::LINES_DEFAULT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire tlcc_pkg::item_t  q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tlcc_pkg::res_t        out_o
);

  localparam int STORE = (LINES > tlcc_pkg::LINE_FIELD_MAX) ? tlcc_pkg::LINE_FIELD_MAX : LINES;
  localparam int IDXW  = (STORE > 1) ? $clog2(STORE) : 1;

  typedef struct packed {
    tlcc_pkg::line_state_e st;
    logic [3:0]            peer;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_WRITE2 = 6'b001000,
    S_EMIT0  = 6'b010000,
    S_EMIT1  = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  // line table, entries read as on hook with no peer until first written
  entry_t           mem_q [STORE];
  logic [STORE-1:0] written_q;
  logic [IDXW-1:0]  rd_a_addr, rd_b_addr, wr_addr;
  logic             we;
  entry_t           wr_data;
  entry_t           rd_a_q, rd_b_q, ent_a, ent_b;
  logic             rd_a_vld_q, rd_b_vld_q;

  tlcc_pkg::item_t  item_q;
  entry_t           own_q, tgt_q;

  // results of the execute step
  tlcc_pkg::res_t   r0, r1, res0_q, res1_q;
  logic             two, two_q;
  logic             w0_en, w1_en, w1_en_q;
  logic [3:0]       w0_line, w1_line, w1_line_q;
  entry_t           w0_data, w1_data, w1_data_q;

  tlcc_pkg::res_t   out_q;
  logic             out_valid_q, out_valid_d, can_load, emit;

  assign ent_a = rd_a_vld_q ? rd_a_q : '0;
  assign ent_b = rd_b_vld_q ? rd_b_q : '0;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;

  // read addresses: own line and target first, then the peer of the own line
  assign rd_a_addr = q_item_i.line[IDXW-1:0];
  assign rd_b_addr = (state_q == S_READ) ? ent_a.peer[IDXW-1:0]
                                         : q_item_i.target_line[IDXW-1:0];

  // event decode on the looked-up entries
  always_comb begin
    tlcc_pkg::line_state_e st;
    logic [3:0]            pl;
    st      = own_q.st;
    pl      = own_q.peer;
    r0      = tlcc_pkg::make_notice(item_q.line, st, pl, tlcc_pkg::STATUS_OK, 1'b1);
    r1      = r0;
    two     = 1'b0;
    w0_en   = 1'b0;
    w0_line = item_q.line;
    w0_data = own_q;
    w1_en   = 1'b0;
    w1_line = pl;
    w1_data = ent_b;
    if (!item_q.line_ok) begin
      r0.dest_line  = item_q.line;
      r0.line_state = tlcc_pkg::ST_ERROR;
      r0.peer_ext   = 4'd0;
      r0.status     = tlcc_pkg::STATUS_ERR;
    end else begin
      case (item_q.cmd)
        tlcc_pkg::CMD_PICKUP: begin
          if (st == tlcc_pkg::ST_ON_HOOK) begin
            w0_en      = 1'b1;
            w0_data.st = tlcc_pkg::ST_DIAL_TONE;
            r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_DIAL_TONE, pl,
                                       tlcc_pkg::STATUS_OK, 1'b1);
          end else if (st == tlcc_pkg::ST_RINGING) begin
            w0_en      = 1'b1;
            w0_data.st = tlcc_pkg::ST_CONNECTED;
            w1_en      = 1'b1;
            w1_data.st = tlcc_pkg::ST_CONNECTED;
            two        = 1'b1;
            r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_CONNECTED, pl,
                                       tlcc_pkg::STATUS_OK, 1'b0);
            r1 = tlcc_pkg::make_notice(pl, tlcc_pkg::ST_CONNECTED, ent_b.peer,
                                       tlcc_pkg::STATUS_OK, 1'b1);
          end
        end
        tlcc_pkg::CMD_HANGUP: begin
          w0_en = 1'b1;
          if (st == tlcc_pkg::ST_CONNECTED || st == tlcc_pkg::ST_RINGING ||
              st == tlcc_pkg::ST_RING_BACK) begin
            w0_data.st   = tlcc_pkg::ST_ON_HOOK;
            w0_data.peer = 4'd0;
            w1_en        = 1'b1;
            w1_data.st   = (st == tlcc_pkg::ST_RING_BACK) ? tlcc_pkg::ST_ON_HOOK
                                                          : tlcc_pkg::ST_DIAL_TONE;
            w1_data.peer = 4'd0;
            two          = 1'b1;
            r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_ON_HOOK, 4'd0,
                                       tlcc_pkg::STATUS_OK, 1'b0);
            r1 = tlcc_pkg::make_notice(pl, w1_data.st, 4'd0, tlcc_pkg::STATUS_OK, 1'b1);
          end else begin
            w0_data.st = tlcc_pkg::ST_ON_HOOK;
            r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_ON_HOOK, pl,
                                       tlcc_pkg::STATUS_OK, 1'b1);
          end
        end
        tlcc_pkg::CMD_DIAL: begin
          if (st == tlcc_pkg::ST_DIAL_TONE) begin
            w0_en = 1'b1;
            if (!item_q.target_ok) begin
              w0_data.st = tlcc_pkg::ST_ERROR;
              r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_ERROR, pl,
                                         tlcc_pkg::STATUS_ERR, 1'b1);
            end else if (item_q.target_line == item_q.line ||
                         tgt_q.st != tlcc_pkg::ST_ON_HOOK) begin
              w0_data.st = tlcc_pkg::ST_BUSY;
              r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_BUSY, pl,
                                         tlcc_pkg::STATUS_OK, 1'b1);
            end else begin
              w0_data.st   = tlcc_pkg::ST_RING_BACK;
              w0_data.peer = item_q.target_line;
              w1_en        = 1'b1;
              w1_line      = item_q.target_line;
              w1_data.st   = tlcc_pkg::ST_RINGING;
              w1_data.peer = item_q.line;
              two          = 1'b1;
              r0 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_RING_BACK, 4'd0,
                                         tlcc_pkg::STATUS_OK, 1'b0);
              r1 = tlcc_pkg::make_notice(item_q.target_line, tlcc_pkg::ST_RINGING, 4'd0,
                                         tlcc_pkg::STATUS_OK, 1'b1);
            end
          end
        end
        tlcc_pkg::CMD_CHAT: begin
          if (st != tlcc_pkg::ST_CONNECTED) begin
            r0.status = tlcc_pkg::STATUS_ERR;
          end else begin
            two           = 1'b1;
            r0.kind       = tlcc_pkg::KIND_CHAT;
            r0.dest_line  = pl;
            r0.line_state = tlcc_pkg::ST_CONNECTED;
            r0.peer_ext   = item_q.line;
            r0.status     = tlcc_pkg::STATUS_OK;
            r0.last       = 1'b0;
            r1 = tlcc_pkg::make_notice(item_q.line, tlcc_pkg::ST_CONNECTED, pl,
                                       tlcc_pkg::STATUS_OK, 1'b1);
          end
        end
        default: begin
          r0.status = tlcc_pkg::STATUS_ERR;
        end
      endcase
    end
  end

  // single write port: own line in the execute step, the other line after it
  always_comb begin
    we      = 1'b0;
    wr_addr = w0_line[IDXW-1:0];
    wr_data = w0_data;
    if (state_q == S_EXEC) begin
      we = w0_en;
    end else if (state_q == S_WRITE2) begin
      we      = w1_en_q;
      wr_addr = w1_line_q[IDXW-1:0];
      wr_data = w1_data_q;
    end
  end

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    case (state_q)
      S_IDLE:   if (q_valid_i) state_d = S_READ;
      S_READ:   state_d = S_EXEC;
      S_EXEC:   state_d = S_WRITE2;
      S_WRITE2: state_d = S_EMIT0;
      S_EMIT0: begin
        if (can_load) begin
          emit    = 1'b1;
          state_d = two_q ? S_EMIT1 : S_IDLE;
        end
      end
      S_EMIT1: begin
        if (can_load) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        written_q[wr_addr] <= 1'b1;
      end
    end
  end

  // memory ports, registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q     <= mem_q[rd_a_addr];
    rd_a_vld_q <= written_q[rd_a_addr];
    rd_b_q     <= mem_q[rd_b_addr];
    rd_b_vld_q <= written_q[rd_b_addr];
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == S_READ) begin
      own_q <= ent_a;
      tgt_q <= ent_b;
    end
    if (state_q == S_EXEC) begin
      res0_q    <= r0;
      res1_q    <= r1;
      two_q     <= two;
      w1_en_q   <= w1_en;
      w1_line_q <= w1_line;
      w1_data_q <= w1_data;
    end
    if (emit) begin
      out_q <= (state_q == S_EMIT1) ? res1_q : res0_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/telephone_line_call_control_top.sv
// telephone_line_call_control_top: call control for a set of telephone lines
// ties tlcc_front, tlcc_queue and tlcc_back together; uses tlcc_pkg
//
// usage
// - input channel: in_valid_i with cmd_i, line_i, target_line_i, target_valid_i;
//   an item is taken at a clock edge with in_valid_i high and in_stall_o low
// - output channel: out_valid_o with kind_o, dest_line_o, line_state_o,
//   peer_ext_o, status_o, last_o; a result is taken when out_stall_i is low
// - each item gives one or two results, the final one with last_o set
// - when idle, an item passes the front register and the queue into the back
//   end; the back end takes a new item only once done with the last one, its
//   sequencer stepping through read own line and target, read peer, execute,
//   second table write and each result through the output register, over the
//   single write port of the line table
// - the front register and a two-item queue keep taking items while the back
//   end works, so in_stall_o rises only when both are full
// - when out_stall_i is high the result register holds, the back end waits,
//   and after the queue fills the input stalls too
// - reset (rst_ni low, asynchronous) puts every line on hook with no peer and
//   empties the queue and output; no clearing pass, the table is usable at once
// - LINES sets the number of lines; line numbers at or above it are rejected
`default_nettype none

module telephone_line_call_control_top #(
  parameter int LINES = tlcc_pkg::LINES_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [3:0] line_i,
  input  wire logic [3:0] target_line_i,
  input  wire logic       target_valid_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [3:0]      dest_line_o,
  output logic [2:0]      line_state_o,
  output logic [3:0]      peer_ext_o,
  output logic            status_o,
  output logic            last_o
);

  // front to queue
  logic            push;
  logic            full;
  tlcc_pkg::item_t front_item;

  // queue to back
  logic            q_valid;
  logic            q_pop;
  tlcc_pkg::item_t q_item;

  tlcc_pkg::res_t  res;

  // classify incoming events
  tlcc_front #(
    .LINES(LINES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .line_i         (line_i),
    .target_line_i  (target_line_i),
    .target_valid_i (target_valid_i),
    .push_o         (push),
    .full_i         (full),
    .item_o         (front_item)
  );

  // decouples the front from the sequencer
  tlcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // line table and event execution
  tlcc_back #(
    .LINES(LINES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign kind_o       = res.kind;
  assign dest_line_o  = res.dest_line;
  assign line_state_o = res.line_state;
  assign peer_ext_o   = res.peer_ext;
  assign status_o     = res.status;
  assign last_o       = res.last;

endmodule

`default_nettype wire

### hw/rtl/tlcc_checker.sv
// tlcc_checker: port-level checks on the call control result channel
// bound to telephone_line_call_control_top; uses tlcc_pkg
`default_nettype none

module tlcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       kind_o,
  input wire logic [3:0] dest_line_o,
  input wire logic [2:0] line_state_o,
  input wire logic [3:0] peer_ext_o,
  input wire logic       status_o,
  input wire logic       last_o
);

  // a chat marker is never the last result and always carries a live call
  a_chat_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tlcc_pkg::KIND_CHAT |->
      !last_o && line_state_o == tlcc_pkg::ST_CONNECTED &&
      status_o == tlcc_pkg::STATUS_OK)
    else $error("chat marker with bad fields");

  // the peer is shown only on connected lines
  a_peer_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tlcc_pkg::KIND_NOTICE &&
    line_state_o != tlcc_pkg::ST_CONNECTED |-> peer_ext_o == 4'd0)
    else $error("peer shown on a line that is not connected");

  // after a taken non-final result the next one follows right away
  a_pair_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("second result of an item missing");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(dest_line_o) &&
      $stable(line_state_o) && $stable(peer_ext_o) && $stable(status_o) &&
      $stable(last_o))
    else $error("stalled result changed");

endmodule

bind telephone_line_call_control_top tlcc_checker u_tlcc_checker (.*);

`default_nettype wire
